@@ hdl/assert_macros.svh @@
// Assertion macros shared by the band onset gate RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define BOG_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// ante implies cons in the same cycle
`define BOG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define BOG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bog_pkg.sv @@
// Package for the band onset gate: defaults, register indexes, controller states
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package bog_pkg;

    localparam int MAX_BANDS_DEF  = 32;
    localparam int MAX_SMOOTH_DEF = 16;
    localparam int MAX_THRESH_DEF = 64;
    localparam int DATA_WIDTH_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 8;
    localparam int BAND_NUM_W = 5;
    localparam int THRESH_W   = 16;
    localparam int REFR_W     = 8;
    localparam int WARM_W     = 16;
    localparam int SLEN_W     = 5;
    localparam int TLEN_W     = 7;
    localparam int FRAME_W    = 16;

    localparam int MIN_STATS    = 8;
    localparam int K_UNITY      = 256;
    localparam int THRESH_RESET = 256;
    localparam int SLEN_RESET   = 4;
    localparam int TLEN_RESET   = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETECT_MODE = 3'd0,
        CFG_THRESHOLD   = 3'd1,
        CFG_REFRACTORY  = 3'd2,
        CFG_WARMUP      = 3'd3,
        CFG_SMOOTH_LEN  = 3'd4,
        CFG_THRESH_LEN  = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_PUSH,
        ST_SEL_START,
        ST_SEL_SCAN,
        ST_SEL_BIT,
        ST_MULT,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic accept;
        logic acc_sum;
        logic div_init;
        logic div_step;
        logic push;
        logic sel_init;
        logic sel_bit;
        logic scan_sel;
        logic acc_cnt;
        logic mult;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic use_stats;
        logic bit_last;
        logic sel_last;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

@@ hdl/bog_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bog_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/bog_ctrl.sv @@
// Controller of the band onset gate: sequences accept, mean, selection and decision.
// Depends on bog_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bog_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire bog_pkg::dp_sts_t sts,
    output bog_pkg::dp_cmd_t      cmd
);

    bog_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bog_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bog_pkg::ST_IDLE:      if (s_tvalid) state_next = bog_pkg::ST_SUM;
            bog_pkg::ST_SUM:       if (sts.scan_done) state_next = bog_pkg::ST_DIV_INIT;
            bog_pkg::ST_DIV_INIT:  state_next = bog_pkg::ST_DIV;
            bog_pkg::ST_DIV:       if (sts.div_done) state_next = bog_pkg::ST_PUSH;
            bog_pkg::ST_PUSH: begin
                state_next = sts.use_stats ? bog_pkg::ST_SEL_START : bog_pkg::ST_DECIDE;
            end
            bog_pkg::ST_SEL_START: state_next = bog_pkg::ST_SEL_SCAN;
            bog_pkg::ST_SEL_SCAN:  if (sts.scan_done) state_next = bog_pkg::ST_SEL_BIT;
            bog_pkg::ST_SEL_BIT: begin
                if (!sts.bit_last) begin
                    state_next = bog_pkg::ST_SEL_SCAN;
                end else if (sts.sel_last) begin
                    state_next = bog_pkg::ST_MULT;
                end else begin
                    state_next = bog_pkg::ST_SEL_START;
                end
            end
            bog_pkg::ST_MULT:      state_next = bog_pkg::ST_DECIDE;
            bog_pkg::ST_DECIDE:    if (sts.out_free) state_next = bog_pkg::ST_IDLE;
            default:               state_next = bog_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            bog_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            bog_pkg::ST_SUM:       cmd.acc_sum  = 1'b1;
            bog_pkg::ST_DIV_INIT:  cmd.div_init = 1'b1;
            bog_pkg::ST_DIV:       cmd.div_step = !sts.div_done;
            bog_pkg::ST_PUSH:      cmd.push     = 1'b1;
            bog_pkg::ST_SEL_START: begin
                cmd.sel_init = 1'b1;
                cmd.scan_sel = 1'b1;
            end
            bog_pkg::ST_SEL_SCAN:  cmd.acc_cnt  = 1'b1;
            bog_pkg::ST_SEL_BIT: begin
                cmd.sel_bit  = 1'b1;
                cmd.scan_sel = !sts.bit_last;
            end
            bog_pkg::ST_MULT:      cmd.mult     = 1'b1;
            bog_pkg::ST_DECIDE:    cmd.commit   = sts.out_free;
            default:               cmd          = '0;
        endcase
    end

    `BOG_ASSERT_NXT(a_accept_to_sum, aclk, aresetn, cmd.accept, state_reg == bog_pkg::ST_SUM, "accepted word did not start the mean scan")
    `BOG_ASSERT_IMP(a_commit_only_decide, aclk, aresetn, cmd.commit, state_reg == bog_pkg::ST_DECIDE && sts.out_free, "commit outside decision")
    `BOG_ASSERT_IMP(a_ready_only_idle, aclk, aresetn, s_tready, state_reg == bog_pkg::ST_IDLE, "input ready outside idle")

endmodule

`default_nettype wire

@@ hdl/bog_dp.sv @@
// Datapath of the band onset gate: config registers, per-band state, history RAMs,
// moving-mean divider, radix rank selection for median/MAD, decision and output register.
// Depends on bog_pkg, bog_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bog_dp #(
    parameter int MAX_BANDS  = bog_pkg::MAX_BANDS_DEF,
    parameter int MAX_SMOOTH = bog_pkg::MAX_SMOOTH_DEF,
    parameter int MAX_THRESH = bog_pkg::MAX_THRESH_DEF,
    parameter int DATA_WIDTH = bog_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire bog_pkg::dp_cmd_t                 cmd,
    output bog_pkg::dp_sts_t                      sts,
    input  wire logic [DATA_WIDTH-1:0]            in_energy,
    input  wire logic                             in_last,
    input  wire logic                             cfg_wr_en,
    input  wire logic [bog_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bog_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             m_tready,
    output logic                                  m_tvalid,
    output logic      [bog_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                                  m_tlast
);

    localparam int W    = DATA_WIDTH;
    localparam int BW   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int SPW  = (MAX_SMOOTH > 1) ? $clog2(MAX_SMOOTH) : 1;
    localparam int TPW  = (MAX_THRESH > 1) ? $clog2(MAX_THRESH) : 1;
    localparam int PW   = (SPW > TPW) ? SPW : TPW;
    localparam int SCW  = $clog2(MAX_SMOOTH + 1);
    localparam int TCW  = $clog2(MAX_THRESH + 1);
    localparam int LCW  = (SCW > TCW) ? SCW : TCW;
    localparam int SUMW = W + SCW;
    localparam int DCW  = $clog2(SUMW + 1);
    localparam int VW   = W + 1;
    localparam int PRW  = bog_pkg::THRESH_W + VW + 1;
    localparam int CMPW = PRW + 1;
    localparam int PADW = bog_pkg::OUT_DATA_W - bog_pkg::BAND_NUM_W - 1;
    localparam logic [1:0] SEL_LAST = 2'd3;

    // configuration
    logic                          cfg_mode_reg;
    logic [bog_pkg::THRESH_W-1:0]  cfg_thr_reg;
    logic [bog_pkg::REFR_W-1:0]    cfg_refr_reg;
    logic [bog_pkg::WARM_W-1:0]    cfg_warm_reg;
    logic [bog_pkg::SLEN_W-1:0]    cfg_slen_reg;
    logic [bog_pkg::TLEN_W-1:0]    cfg_tlen_reg;

    // per-band state
    logic [W-1:0]                  prev_energy_reg [MAX_BANDS];
    logic [SCW-1:0]                scount_reg      [MAX_BANDS];
    logic [SPW-1:0]                sptr_reg        [MAX_BANDS];
    logic [TCW-1:0]                tcount_reg      [MAX_BANDS];
    logic [TPW-1:0]                tptr_reg        [MAX_BANDS];
    logic [W-1:0]                  prev_sm_reg     [MAX_BANDS];
    logic                          was_above_reg   [MAX_BANDS];
    logic [bog_pkg::REFR_W-1:0]    refr_reg        [MAX_BANDS];

    logic [BW-1:0]                 band_pos_reg;
    logic [bog_pkg::FRAME_W-1:0]   frame_count_reg;
    logic                          det_en_reg;

    // working registers
    logic                          eof_reg;
    logic [SCW-1:0]                ns_reg;
    logic [SUMW-1:0]               sum_reg;
    logic [SUMW-1:0]               div_num_reg;
    logic [SCW-1:0]                div_rem_reg;
    logic [DCW-1:0]                div_cnt_reg;
    logic [TCW-1:0]                nt_reg;
    logic                          use_stats_reg;
    logic [PW-1:0]                 scan_ptr_reg;
    logic [LCW-1:0]                scan_left_reg;
    logic                          scan_kind_reg;
    logic                          rd_vld_reg;
    logic [1:0]                    sel_num_reg;
    logic [TCW-1:0]                rank_reg;
    logic [VW-1:0]                 pfx_reg;
    logic [VW-1:0]                 mask_reg;
    logic [VW-1:0]                 cur_reg;
    logic [TCW-1:0]                cnt_reg;
    logic [VW-1:0]                 m2_reg;
    logic [VW:0]                   mad4_reg;
    logic [PRW-1:0]                prod_reg;
    logic                          m_valid_reg;
    logic                          m_hit_reg;
    logic [bog_pkg::BAND_NUM_W-1:0] m_band_reg;
    logic                          m_last_reg;

    // combinational
    logic [BW-1:0]                 b;
    logic [SCW:0]                  slen_w, s_inc;
    logic [TCW:0]                  tlen_w, t_inc;
    logic [SCW-1:0]                ns_w;
    logic [TCW-1:0]                nt_w;
    logic [SPW-1:0]                sptr_new;
    logic [TPW-1:0]                tptr_new;
    logic [W-1:0]                  odf;
    logic [bog_pkg::REFR_W-1:0]    refr_dec;
    logic [bog_pkg::FRAME_W-1:0]   fc_inc;
    logic [W-1:0]                  rd_s, rd_t, mean;
    logic                          issue;
    logic [PW-1:0]                 ptr_dec;
    logic [VW-1:0]                 v2, diff, val, pfx_next;
    logic                          match, take_one;
    logic [TCW-1:0]                half, rank_lo, rank_next;
    logic [SCW:0]                  rem_sh;
    logic                          qbit;
    logic [SCW-1:0]                rem_new;
    logic [bog_pkg::THRESH_W-1:0]  k;
    logic [CMPW-1:0]               lhs, rhs;
    logic                          above, rising, hit;
    logic [31:0]                   sl32, tl32;

    assign b = band_pos_reg;

    always_comb begin
        sl32 = 32'(cfg_slen_reg);
        tl32 = 32'(cfg_tlen_reg);
        if (sl32 == 32'd0) begin
            slen_w = (SCW+1)'(1);
        end else if (sl32 > 32'(MAX_SMOOTH)) begin
            slen_w = (SCW+1)'(MAX_SMOOTH);
        end else begin
            slen_w = (SCW+1)'(sl32);
        end
        if (tl32 == 32'd0) begin
            tlen_w = (TCW+1)'(1);
        end else if (tl32 > 32'(MAX_THRESH)) begin
            tlen_w = (TCW+1)'(MAX_THRESH);
        end else begin
            tlen_w = (TCW+1)'(tl32);
        end
    end

    assign s_inc = (SCW+1)'(scount_reg[b]) + (SCW+1)'(1);
    assign t_inc = (TCW+1)'(tcount_reg[b]) + (TCW+1)'(1);
    assign ns_w  = (s_inc > slen_w) ? SCW'(slen_w) : SCW'(s_inc);
    assign nt_w  = (t_inc > tlen_w) ? TCW'(tlen_w) : TCW'(t_inc);

    assign sptr_new = (sptr_reg[b] == SPW'(MAX_SMOOTH - 1)) ? '0 : sptr_reg[b] + SPW'(1);
    assign tptr_new = (tptr_reg[b] == TPW'(MAX_THRESH - 1)) ? '0 : tptr_reg[b] + TPW'(1);

    always_comb begin
        if (cfg_mode_reg) begin
            odf = in_energy;
        end else if (scount_reg[b] == '0) begin
            odf = '0;
        end else if (in_energy > prev_energy_reg[b]) begin
            odf = in_energy - prev_energy_reg[b];
        end else begin
            odf = '0;
        end
    end

    assign refr_dec = (refr_reg[b] != '0) ? refr_reg[b] - 1'b1 : '0;
    assign fc_inc   = (frame_count_reg == '1) ? frame_count_reg : frame_count_reg + 1'b1;

    // history memories, one row per band
    bog_ram #(.WIDTH(W), .DEPTH(2 ** (BW + SPW))) u_smooth_ram (
        .clk   (aclk),
        .we    (cmd.accept),
        .waddr ({b, sptr_new}),
        .wdata (odf),
        .raddr ({b, scan_ptr_reg[SPW-1:0]}),
        .rdata (rd_s)
    );

    bog_ram #(.WIDTH(W), .DEPTH(2 ** (BW + TPW))) u_thresh_ram (
        .clk   (aclk),
        .we    (cmd.push),
        .waddr ({b, tptr_new}),
        .wdata (mean),
        .raddr ({b, scan_ptr_reg[TPW-1:0]}),
        .rdata (rd_t)
    );

    assign issue   = (scan_left_reg != '0);
    assign ptr_dec = (scan_ptr_reg != '0) ? scan_ptr_reg - PW'(1) :
                     (scan_kind_reg ? PW'(MAX_THRESH - 1) : PW'(MAX_SMOOTH - 1));

    // rank selection: count entries that agree with the decided prefix and have a zero here
    assign v2       = {rd_t, 1'b0};
    assign diff     = (v2 >= m2_reg) ? v2 - m2_reg : m2_reg - v2;
    assign val      = sel_num_reg[1] ? diff : {1'b0, rd_t};
    assign match    = (((val ^ pfx_reg) & mask_reg) == '0) && ((val & cur_reg) == '0);
    assign take_one = (rank_reg >= cnt_reg);
    assign pfx_next = take_one ? (pfx_reg | cur_reg) : pfx_reg;
    assign rank_next = take_one ? rank_reg - cnt_reg : rank_reg;
    assign half     = nt_reg >> 1;
    assign rank_lo  = nt_reg[0] ? half : half - TCW'(1);

    // restoring divider, one quotient bit a cycle
    assign rem_sh  = {div_rem_reg, div_num_reg[SUMW-1]};
    assign qbit    = (rem_sh >= {1'b0, ns_reg});
    assign rem_new = qbit ? SCW'(rem_sh - {1'b0, ns_reg}) : SCW'(rem_sh);
    assign mean    = div_num_reg[W-1:0];

    assign k      = (cfg_thr_reg == '0) ? bog_pkg::THRESH_W'(bog_pkg::K_UNITY) : cfg_thr_reg;
    assign lhs    = CMPW'({mean, 10'b0});
    assign rhs    = CMPW'({m2_reg, 9'b0}) + CMPW'(prod_reg);
    assign above  = use_stats_reg ? (lhs > rhs) : (32'(mean) > 32'(cfg_thr_reg));
    assign rising = (mean >= prev_sm_reg[b]);
    assign hit    = det_en_reg && (refr_reg[b] == '0) && above && !was_above_reg[b] && rising;

    always_comb begin
        sts.scan_done = !issue && !rd_vld_reg;
        sts.div_done  = (div_cnt_reg == '0);
        sts.use_stats = (32'(nt_w) >= bog_pkg::MIN_STATS);
        sts.bit_last  = cur_reg[0];
        sts.sel_last  = (sel_num_reg == SEL_LAST);
        sts.out_free  = !m_valid_reg || m_tready;
    end

    // control state and per-band state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mode_reg    <= 1'b0;
            cfg_thr_reg     <= bog_pkg::THRESH_W'(bog_pkg::THRESH_RESET);
            cfg_refr_reg    <= '0;
            cfg_warm_reg    <= '0;
            cfg_slen_reg    <= bog_pkg::SLEN_W'(bog_pkg::SLEN_RESET);
            cfg_tlen_reg    <= bog_pkg::TLEN_W'(bog_pkg::TLEN_RESET);
            for (int i = 0; i < MAX_BANDS; i++) begin
                prev_energy_reg[i] <= '0;
                scount_reg[i]      <= '0;
                sptr_reg[i]        <= '0;
                tcount_reg[i]      <= '0;
                tptr_reg[i]        <= '0;
                prev_sm_reg[i]     <= '0;
                was_above_reg[i]   <= 1'b0;
                refr_reg[i]        <= '0;
            end
            band_pos_reg    <= '0;
            frame_count_reg <= '0;
            det_en_reg      <= 1'b0;
            scan_left_reg   <= '0;
            rd_vld_reg      <= 1'b0;
            div_cnt_reg     <= '0;
            sel_num_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    bog_pkg::CFG_DETECT_MODE: cfg_mode_reg <= cfg_data[0];
                    bog_pkg::CFG_THRESHOLD:   cfg_thr_reg  <= cfg_data[bog_pkg::THRESH_W-1:0];
                    bog_pkg::CFG_REFRACTORY:  cfg_refr_reg <= cfg_data[bog_pkg::REFR_W-1:0];
                    bog_pkg::CFG_WARMUP:      cfg_warm_reg <= cfg_data[bog_pkg::WARM_W-1:0];
                    bog_pkg::CFG_SMOOTH_LEN:  cfg_slen_reg <= cfg_data[bog_pkg::SLEN_W-1:0];
                    bog_pkg::CFG_THRESH_LEN:  cfg_tlen_reg <= cfg_data[bog_pkg::TLEN_W-1:0];
                    default: ;
                endcase
            end

            rd_vld_reg <= issue;
            if (issue) begin
                scan_left_reg <= scan_left_reg - LCW'(1);
            end

            if (cmd.accept) begin
                if (b == '0) begin
                    frame_count_reg <= fc_inc;
                    if (fc_inc >= cfg_warm_reg) begin
                        det_en_reg <= 1'b1;
                    end
                end
                refr_reg[b]        <= refr_dec;
                prev_energy_reg[b] <= in_energy;
                scount_reg[b]      <= ns_w;
                sptr_reg[b]        <= sptr_new;
                scan_left_reg      <= LCW'(ns_w);
            end

            if (cmd.scan_sel) begin
                scan_left_reg <= LCW'(nt_reg);
            end

            if (cmd.div_init) begin
                div_cnt_reg <= DCW'(SUMW);
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg - DCW'(1);
            end

            if (cmd.push) begin
                tcount_reg[b] <= nt_w;
                tptr_reg[b]   <= tptr_new;
                sel_num_reg   <= '0;
            end

            if (cmd.sel_bit && cur_reg[0]) begin
                sel_num_reg <= sel_num_reg + 2'd1;
            end

            if (cmd.commit) begin
                was_above_reg[b] <= det_en_reg ? above : 1'b0;
                if (hit) begin
                    refr_reg[b] <= cfg_refr_reg;
                end
                prev_sm_reg[b] <= mean;
                band_pos_reg   <= (eof_reg || b == BW'(MAX_BANDS - 1)) ? '0 : b + BW'(1);
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            eof_reg       <= in_last;
            ns_reg        <= ns_w;
            sum_reg       <= '0;
            scan_ptr_reg  <= PW'(sptr_new);
            scan_kind_reg <= 1'b0;
        end else if (cmd.scan_sel) begin
            scan_ptr_reg  <= PW'(tptr_reg[b]);
            scan_kind_reg <= 1'b1;
        end else if (issue) begin
            scan_ptr_reg  <= ptr_dec;
        end

        if (cmd.acc_sum && rd_vld_reg) begin
            sum_reg <= sum_reg + SUMW'(rd_s);
        end

        if (cmd.div_init) begin
            div_num_reg <= sum_reg + SUMW'(ns_reg >> 1);
            div_rem_reg <= '0;
        end else if (cmd.div_step) begin
            div_num_reg <= {div_num_reg[SUMW-2:0], qbit};
            div_rem_reg <= rem_new;
        end

        if (cmd.push) begin
            nt_reg        <= nt_w;
            use_stats_reg <= sts.use_stats;
        end

        if (cmd.scan_sel) begin
            cnt_reg <= '0;
        end else if (cmd.acc_cnt && rd_vld_reg && match) begin
            cnt_reg <= cnt_reg + TCW'(1);
        end

        if (cmd.sel_init) begin
            rank_reg <= sel_num_reg[0] ? half : rank_lo;
            pfx_reg  <= '0;
            mask_reg <= '0;
            cur_reg  <= {1'b1, {(VW-1){1'b0}}};
        end else if (cmd.sel_bit) begin
            rank_reg <= rank_next;
            pfx_reg  <= pfx_next;
            mask_reg <= mask_reg | cur_reg;
            cur_reg  <= cur_reg >> 1;
            // fold the finished rank into median or MAD
            if (cur_reg[0]) begin
                case (sel_num_reg)
                    2'd0:    m2_reg   <= pfx_next;
                    2'd1:    m2_reg   <= m2_reg + pfx_next;
                    2'd2:    mad4_reg <= {1'b0, pfx_next};
                    default: mad4_reg <= mad4_reg + {1'b0, pfx_next};
                endcase
            end
        end

        if (cmd.mult) begin
            prod_reg <= PRW'(k * mad4_reg);
        end

        if (cmd.commit) begin
            m_hit_reg  <= hit;
            m_band_reg <= bog_pkg::BAND_NUM_W'(b);
            m_last_reg <= eof_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PADW{1'b0}}, m_band_reg, m_hit_reg};
    assign m_tlast  = m_last_reg;

    `BOG_ASSERT(a_band_range, aclk, aresetn, 32'(band_pos_reg) < MAX_BANDS, "band position out of range")
    `BOG_ASSERT_IMP(a_read_consumed, aclk, aresetn, rd_vld_reg, cmd.acc_sum || cmd.acc_cnt, "history read data dropped")
    `BOG_ASSERT_IMP(a_push_after_div, aclk, aresetn, cmd.push, div_cnt_reg == '0, "mean pushed before division ended")

endmodule

`default_nettype wire

@@ hdl/band_onset_gate_core.sv @@
// Band onset gate: per-band onset detector with a median/MAD adaptive threshold.
// Channels: s_ stream takes one band energy word per band (tlast on a frame's last
// band); m_ stream gives one result word per band; cfg_ port writes the registers.
// One band at a time: between one accept and the next a band runs the mean scan over Ns
//   entries, with Ns the moving-mean length, the divider set-up, a division of SUMW quotient bits,
//   SUMW = DATA_WIDTH + clog2(MAX_SMOOTH + 1), and the push; once 8 or more means are held the
//   four rank selections over the Nt threshold window entries and a multiply follow, then the decision.
// The rank selection of median and MAD dominates: one history RAM read per cycle,
// each of four ranks resolved one bit per pass over the window.
// The result sits in an output register: the next band is accepted while it waits.
// If the receiver stalls with that register full, the block holds its finished
// decision and stops accepting until the word is taken.
// Reset (aresetn low, synchronous) loads register defaults and clears per-band state;
// history RAM contents are not cleared, as only written entries are ever read.
// Depends on bog_pkg, bog_ctrl, bog_dp and bog_ram.
`default_nettype none

module band_onset_gate_core #(
    parameter int MAX_BANDS  = bog_pkg::MAX_BANDS_DEF,
    parameter int MAX_SMOOTH = bog_pkg::MAX_SMOOTH_DEF,
    parameter int MAX_THRESH = bog_pkg::MAX_THRESH_DEF,
    parameter int DATA_WIDTH = bog_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // band_energy
    input  wire logic                                 s_tlast,   // end_of_frame
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [bog_pkg::OUT_DATA_W-1:0]       m_tdata,   // hit, band_number[4:0]
    output logic                                      m_tlast,   // frame_last
    input  wire logic                                 cfg_wr_en,
    input  wire logic [bog_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [bog_pkg::CFG_DATA_W-1:0]       cfg_data
);

    bog_pkg::dp_cmd_t cmd;
    bog_pkg::dp_sts_t sts;

    bog_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bog_dp #(
        .MAX_BANDS  (MAX_BANDS),
        .MAX_SMOOTH (MAX_SMOOTH),
        .MAX_THRESH (MAX_THRESH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_energy (s_tdata[DATA_WIDTH-1:0]),
        .in_last   (s_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
